// ----- rtl/dsp_pkg.sv -----
// Package for the decimal string parser: character codes, limits,
// the result status codes and the item record passed from front to back.
// No dependencies.
package dsp_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam int MAG_W = 63;
    localparam int NUM_W = 64;
    localparam int FRAC_W = 8;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
    // Largest magnitude that can still be multiplied by ten.
    localparam logic [MAG_W-1:0] MAG_LIM = MAG_MAX / 63'd10;
    localparam logic [FRAC_W-1:0] FRAC_SAT = {FRAC_W{1'b1}};

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_SIGN_ONLY = 3'd2,
        ST_BAD_CHAR  = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    // One classified character.
    typedef struct packed {
        logic       has_char;
        logic       last;
        logic       is_digit;
        logic       is_point;
        logic       is_plus;
        logic       is_minus;
        logic [3:0] digit;
    } t_item;

endpackage

// ----- rtl/decimal_string_parser.sv -----
// Top level of the decimal string parser: joins the front end, the item
// queue and the accumulating back end. Depends on dsp_pkg, dsp_front,
// dsp_queue and dsp_back.
//
// Usage: a string arrives on the s_ channel one character per transaction;
// s_tuser marks whether s_tdata carries a character, and s_tlast closes the
// string. Each closing transaction yields one result transaction on the m_
// channel with the signed numerator (point removed), the count of characters
// after the first point and a status code (ok, empty, sign only, bad
// character, overflow). Other transactions yield nothing.
// Throughput is one character per cycle while the queue is not full; the
// digit step is a shift-add by ten and one 64-bit add and compare in the
// back end. A closing character is written into the queue, and its result
// is registered onto m_tvalid when the back end takes it from the queue.
// Reset clears the queue, the string state and the result valid flag.
// When the receiver stalls, the result holds in its register, the next
// closing character waits at the head of the queue, further characters fill
// the four-entry queue, and s_tready falls only when the queue is full.
module decimal_string_parser
    import dsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] ch
    input  logic [0:0]  s_tuser,  // [0] has_char
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata   // [63:0] numerator, [71:64] frac_digits,
                                  // [74:72] status, [79:75] zero
);

    logic              w_push;
    logic              w_full;
    logic              w_empty;
    logic              w_pop;
    t_item             w_push_item;
    t_item             w_pop_item;
    logic [NUM_W-1:0]  w_num;
    logic [FRAC_W-1:0] w_frac;
    t_status           w_status;

    dsp_front u_front (
        .i_valid    (s_tvalid),
        .i_ch       (s_tdata),
        .i_has_char (s_tuser[0]),
        .i_last     (s_tlast),
        .i_full     (w_full),
        .o_ready    (s_tready),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    dsp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_item  (w_pop_item),
        .o_empty     (w_empty)
    );

    dsp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_item        (w_pop_item),
        .o_pop         (w_pop),
        .o_valid       (m_tvalid),
        .i_ready       (m_tready),
        .o_numerator   (w_num),
        .o_frac_digits (w_frac),
        .o_status      (w_status)
    );

    assign m_tdata = {5'b0, w_status, w_frac, w_num};

endmodule

// ----- rtl/dsp_front.sv -----
// Front end of the decimal string parser: takes input transactions and
// classifies each character before it enters the queue.
// Depends on dsp_pkg.
module dsp_front
    import dsp_pkg::*;
(
    input  logic       i_valid,
    input  logic [7:0] i_ch,
    input  logic       i_has_char,
    input  logic       i_last,
    input  logic       i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_item      o_item
);

    logic [7:0] w_diff;

    assign w_diff  = i_ch - CH_ZERO;
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item          = '0;
        o_item.has_char = i_has_char;
        o_item.last     = i_last;
        o_item.is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        o_item.is_point = (i_ch == CH_POINT);
        o_item.is_plus  = (i_ch == CH_PLUS);
        o_item.is_minus = (i_ch == CH_MINUS);
        o_item.digit    = w_diff[3:0];
    end

endmodule

// ----- rtl/dsp_queue.sv -----
// Small first-in first-out queue of classified characters between the
// front end and the accumulator. Depends on dsp_pkg.
module dsp_queue
    import dsp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_push_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_pop_item,
    output logic  o_empty
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wr;
    logic [QPTR_W-1:0]  n_rd;
    logic [QCNT_W-1:0]  n_count;

    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_item = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("empty queue with unequal pointers");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

// ----- rtl/dsp_back.sv -----
// Back end of the decimal string parser: applies each queued character to
// the number state and registers one result per string. Depends on dsp_pkg.
module dsp_back
    import dsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_item             i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [NUM_W-1:0]  o_numerator,
    output logic [FRAC_W-1:0] o_frac_digits,
    output t_status           o_status
);

    logic [MAG_W-1:0]  r_mag;
    logic              r_neg;
    logic              r_seen_first;
    logic              r_seen_digit;
    logic              r_point;
    logic [FRAC_W-1:0] r_frac;
    t_status           r_err;

    logic [MAG_W-1:0]  n_mag;
    logic              n_neg;
    logic              n_seen_first;
    logic              n_seen_digit;
    logic              n_point;
    logic [FRAC_W-1:0] n_frac;
    t_status           n_err;

    logic              r_out_valid;
    logic [NUM_W-1:0]  r_out_num;
    logic [FRAC_W-1:0] r_out_frac;
    t_status           r_out_status;

    logic [MAG_W-1:0]  s_mag;
    logic              s_neg;
    logic              s_seen_first;
    logic              s_seen_digit;
    logic              s_point;
    logic [FRAC_W-1:0] s_frac;
    t_status           s_err;
    t_status           w_status;
    logic [NUM_W-1:0]  w_mag10;
    logic [NUM_W-1:0]  w_sum;
    logic [NUM_W-1:0]  w_value;
    logic              w_out_free;

    // Times ten as two shifted copies; only used when the magnitude is at
    // most the limit, so the product stays within 63 bits.
    assign w_mag10 = ({1'b0, r_mag} << 3) + ({1'b0, r_mag} << 1);
    assign w_sum   = w_mag10 + NUM_W'(i_item.digit);

    assign w_out_free = !r_out_valid || i_ready;
    // A string end needs the result register; other characters never wait.
    assign o_pop      = !i_empty && (!i_item.last || w_out_free);

    always_comb begin
        s_mag        = r_mag;
        s_neg        = r_neg;
        s_seen_first = r_seen_first;
        s_seen_digit = r_seen_digit;
        s_point      = r_point;
        s_frac       = r_frac;
        s_err        = r_err;

        if (i_item.has_char) begin
            if (r_point) begin
                if (r_frac != FRAC_SAT) begin
                    s_frac = r_frac + 1'b1;
                end
            end
            if (!r_point && i_item.is_point) begin
                s_point = 1'b1;
            end else if (!r_seen_first && (i_item.is_plus || i_item.is_minus)) begin
                s_seen_first = 1'b1;
                s_neg        = i_item.is_minus;
            end else begin
                s_seen_first = 1'b1;
                s_seen_digit = 1'b1;
                if (r_err == ST_OK) begin
                    if (!i_item.is_digit) begin
                        s_err = ST_BAD_CHAR;
                    end else if (r_mag > MAG_LIM) begin
                        s_err = ST_OVERFLOW;
                    end else if (w_sum[NUM_W-1]) begin
                        s_err = ST_OVERFLOW;
                    end else begin
                        s_mag = w_sum[MAG_W-1:0];
                    end
                end
            end
        end

        if (!s_seen_first) begin
            w_status = ST_EMPTY;
        end else if (!s_seen_digit) begin
            w_status = ST_SIGN_ONLY;
        end else begin
            w_status = s_err;
        end

        if (w_status != ST_OK) begin
            w_value = '0;
        end else if (s_neg) begin
            w_value = '0 - {1'b0, s_mag};
        end else begin
            w_value = {1'b0, s_mag};
        end

        if (i_item.last) begin
            n_mag        = '0;
            n_neg        = 1'b0;
            n_seen_first = 1'b0;
            n_seen_digit = 1'b0;
            n_point      = 1'b0;
            n_frac       = '0;
            n_err        = ST_OK;
        end else begin
            n_mag        = s_mag;
            n_neg        = s_neg;
            n_seen_first = s_seen_first;
            n_seen_digit = s_seen_digit;
            n_point      = s_point;
            n_frac       = s_frac;
            n_err        = s_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag        <= '0;
            r_neg        <= 1'b0;
            r_seen_first <= 1'b0;
            r_seen_digit <= 1'b0;
            r_point      <= 1'b0;
            r_frac       <= '0;
            r_err        <= ST_OK;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mag        <= n_mag;
                r_neg        <= n_neg;
                r_seen_first <= n_seen_first;
                r_seen_digit <= n_seen_digit;
                r_point      <= n_point;
                r_frac       <= n_frac;
                r_err        <= n_err;
            end
            if (o_pop && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_out_num    <= w_value;
            r_out_frac   <= s_frac;
            r_out_status <= w_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_numerator   = r_out_num;
    assign o_frac_digits = r_out_frac;
    assign o_status      = r_out_status;

    a_err_num_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_OK)) |-> (r_out_num == '0))
        else $error("nonzero numerator with error status");

    a_err_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err == ST_OK) || (r_err == ST_BAD_CHAR) || (r_err == ST_OVERFLOW))
        else $error("unexpected sticky error code");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.last) |=> (!r_seen_first && !r_point && (r_frac == '0)))
        else $error("string state not cleared after end");

    a_mag_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK) |-> (r_seen_digit && r_seen_first))
        else $error("error recorded without a digit position");

endmodule
